FILE: sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(name, clk, rst_n, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Checks that the antecedent implies the consequent in the same cycle.
`define ASSERT_IMPLIES(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

FILE: sv/scalc_pkg.sv
package scalc_pkg;

    localparam int DEPTH = 1024;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int DW    = 32;
    localparam int OPW   = 3;
    localparam int PW    = 10;
    localparam int STW   = 3;
    localparam int SDW   = 11;

    typedef enum logic [OPW-1:0] {
        OP_PUSH,
        OP_POP,
        OP_PEEK_TOP,
        OP_PEEK_BOT,
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV
    } t_opcode;

    typedef enum logic [STW-1:0] {
        ST_OK,
        ST_EMPTY,
        ST_RANGE,
        ST_FEW,
        ST_DIVZ,
        ST_FULL
    } t_status;

endpackage

FILE: sv/scalc_if.sv
interface scalc_cmd_if;
    logic                              valid;
    logic                              ready;
    logic [scalc_pkg::OPW-1:0]         opcode;
    logic signed [scalc_pkg::DW-1:0]   push_value;
    logic [scalc_pkg::PW-1:0]          peek_index;

    modport source (output valid, opcode, push_value, peek_index, input ready);
    modport sink (input valid, opcode, push_value, peek_index, output ready);
endinterface

interface scalc_rsp_if;
    logic                              valid;
    logic                              ready;
    logic signed [scalc_pkg::DW-1:0]   result_value;
    logic [scalc_pkg::STW-1:0]         status;
    logic [scalc_pkg::SDW-1:0]         stack_depth;

    modport source (output valid, result_value, status, stack_depth, input ready);
    modport sink (input valid, result_value, status, stack_depth, output ready);
endinterface

FILE: sv/scalc_div.sv
module scalc_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [scalc_pkg::DW-1:0]    i_num,
    input  logic [scalc_pkg::DW-1:0]    i_den,
    output logic                        o_done,
    output logic [scalc_pkg::DW-1:0]    o_quo
);

    localparam int DW = scalc_pkg::DW;
    localparam int NW = $clog2(DW);

    logic            r_busy;
    logic            r_done;
    logic [NW-1:0]   r_cnt;
    logic [DW-1:0]   r_rem;
    logic [DW-1:0]   r_q;
    logic [DW-1:0]   r_den;
    logic            r_neg;

    logic [DW:0]     w_trial;
    logic            w_fit;
    logic [DW:0]     w_diff;

    assign w_trial = {r_rem, r_q[DW-1]};
    assign w_fit   = (w_trial >= {1'b0, r_den});
    assign w_diff  = w_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_q    <= i_num[DW-1] ? (~i_num + DW'(1)) : i_num;
                r_den  <= i_den[DW-1] ? (~i_den + DW'(1)) : i_den;
                r_neg  <= i_num[DW-1] ^ i_den[DW-1];
            end else if (r_busy) begin
                r_rem <= w_fit ? w_diff[DW-1:0] : w_trial[DW-1:0];
                r_q   <= {r_q[DW-2:0], w_fit};
                r_cnt <= r_cnt + NW'(1);
                if (r_cnt == NW'(DW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Floor rounding: with differing signs and a nonzero remainder the
    // truncated quotient moves one further down, which is the complement.
    always_comb begin
        if (!r_neg) begin
            o_quo = r_q;
        end else if (r_rem != '0) begin
            o_quo = ~r_q;
        end else begin
            o_quo = ~r_q + DW'(1);
        end
    end

    assign o_done = r_done;

endmodule

FILE: sv/stack_calculator_engine.sv
// Path of an item after accept: push and the empty, range, few and full errors go to S_FIN,
// pop and peek pass S_RD, add, subtract, multiply and divide pass S_RD2 and S_SEC, and a divide
// by a nonzero value then waits in S_DIV for the bit-serial divider. One item is in work at a
// time; the next is accepted in the cycle after the result is loaded into the output register.
// Reset (synchronous, active low) empties the stack and clears the output valid.
// The stack memory itself is not cleared; only written entries are ever read.
`include "assert_macros.svh"

module stack_calculator_engine (
    input  logic          i_clk,
    input  logic          i_rst_n,
    scalc_cmd_if.sink     i_cmd,
    scalc_rsp_if.source   o_rsp
);

    localparam int DEPTH = scalc_pkg::DEPTH;
    localparam int AW    = scalc_pkg::AW;
    localparam int CW    = scalc_pkg::CW;
    localparam int DW    = scalc_pkg::DW;
    localparam int SDW   = scalc_pkg::SDW;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_RD2,
        S_SEC,
        S_DIV,
        S_FIN
    } t_state;

    t_state               r_state;
    scalc_pkg::t_opcode   r_op;
    logic [CW-1:0]        r_count;
    logic [CW-1:0]        r_ncount;
    logic [DW-1:0]        r_top;
    logic [DW-1:0]        r_res;
    logic [DW-1:0]        r_wdata;
    logic [AW-1:0]        r_waddr;
    logic                 r_wr;
    scalc_pkg::t_status   r_st;
    logic [DW-1:0]        r_rdata;

    logic                 r_ovalid;
    logic [DW-1:0]        r_ores;
    scalc_pkg::t_status   r_ost;
    logic [SDW-1:0]       r_odepth;

    logic [DW-1:0]        mem [DEPTH];

    scalc_pkg::t_opcode   w_op;
    logic [CW-1:0]        w_cm1;
    logic [CW-1:0]        w_cm2;
    logic [CW-1:0]        w_top_pos;
    logic                 w_accept;
    logic                 w_slot_free;
    logic                 w_fin;
    logic                 w_we;
    logic [AW-1:0]        w_rd_addr;
    logic                 w_div_start;
    logic                 w_div_done;
    logic [DW-1:0]        w_div_quo;
    logic [DW-1:0]        w_mul;

    assign w_op        = scalc_pkg::t_opcode'(i_cmd.opcode);
    assign w_cm1       = r_count - CW'(1);
    assign w_cm2       = r_count - CW'(2);
    assign w_top_pos   = w_cm1 - CW'(i_cmd.peek_index);
    assign w_accept    = i_cmd.valid && (r_state == S_IDLE);
    assign w_slot_free = !r_ovalid || o_rsp.ready;
    assign w_fin       = (r_state == S_FIN) && w_slot_free;
    assign w_we        = w_fin && r_wr;
    assign w_mul       = r_rdata * r_top;
    assign w_div_start = (r_state == S_SEC) && (r_op == scalc_pkg::OP_DIV) && (r_top != '0);

    always_comb begin
        if (r_state == S_IDLE) begin
            case (w_op)
                scalc_pkg::OP_PEEK_TOP: w_rd_addr = w_top_pos[AW-1:0];
                scalc_pkg::OP_PEEK_BOT: w_rd_addr = AW'(i_cmd.peek_index);
                default:                w_rd_addr = w_cm1[AW-1:0];
            endcase
        end else begin
            w_rd_addr = w_cm2[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= mem[w_rd_addr];
        if (w_we) begin
            mem[r_waddr] <= r_wdata;
        end
    end

    scalc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_rdata),
        .i_den   (r_top),
        .o_done  (w_div_done),
        .o_quo   (w_div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (w_fin) begin
                r_ovalid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_op     <= w_op;
                        r_res    <= '0;
                        r_st     <= scalc_pkg::ST_OK;
                        r_wr     <= 1'b0;
                        r_ncount <= r_count;
                        case (w_op)
                            scalc_pkg::OP_PUSH: begin
                                if (r_count >= CW'(DEPTH)) begin
                                    r_st <= scalc_pkg::ST_FULL;
                                end else begin
                                    r_wr     <= 1'b1;
                                    r_waddr  <= r_count[AW-1:0];
                                    r_wdata  <= i_cmd.push_value;
                                    r_ncount <= r_count + CW'(1);
                                end
                                r_state <= S_FIN;
                            end
                            scalc_pkg::OP_POP: begin
                                if (r_count == '0) begin
                                    r_st    <= scalc_pkg::ST_EMPTY;
                                    r_state <= S_FIN;
                                end else begin
                                    r_ncount <= w_cm1;
                                    r_state  <= S_RD;
                                end
                            end
                            scalc_pkg::OP_PEEK_TOP, scalc_pkg::OP_PEEK_BOT: begin
                                if (DW'(i_cmd.peek_index) >= DW'(r_count)) begin
                                    r_st    <= scalc_pkg::ST_RANGE;
                                    r_state <= S_FIN;
                                end else begin
                                    r_state <= S_RD;
                                end
                            end
                            default: begin
                                if (r_count < CW'(2)) begin
                                    r_st    <= scalc_pkg::ST_FEW;
                                    r_state <= S_FIN;
                                end else begin
                                    r_state <= S_RD2;
                                end
                            end
                        endcase
                    end
                end
                S_RD: begin
                    r_res   <= r_rdata;
                    r_state <= S_FIN;
                end
                S_RD2: begin
                    r_top   <= r_rdata;
                    r_state <= S_SEC;
                end
                S_SEC: begin
                    r_waddr  <= w_cm2[AW-1:0];
                    r_ncount <= w_cm1;
                    r_wr     <= 1'b1;
                    r_state  <= S_FIN;
                    case (r_op)
                        scalc_pkg::OP_ADD: begin
                            r_res   <= r_rdata + r_top;
                            r_wdata <= r_rdata + r_top;
                        end
                        scalc_pkg::OP_SUB: begin
                            r_res   <= r_rdata - r_top;
                            r_wdata <= r_rdata - r_top;
                        end
                        scalc_pkg::OP_MUL: begin
                            r_res   <= w_mul;
                            r_wdata <= w_mul;
                        end
                        default: begin
                            if (r_top == '0) begin
                                r_st     <= scalc_pkg::ST_DIVZ;
                                r_wr     <= 1'b0;
                                r_ncount <= w_cm2;
                            end else begin
                                r_state <= S_DIV;
                            end
                        end
                    endcase
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_res   <= w_div_quo;
                        r_wdata <= w_div_quo;
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (w_slot_free) begin
                        r_ores   <= r_res;
                        r_ost    <= r_st;
                        r_odepth <= SDW'(r_ncount);
                        r_count  <= r_ncount;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_cmd.ready        = (r_state == S_IDLE);
    assign o_rsp.valid        = r_ovalid;
    assign o_rsp.result_value = r_ores;
    assign o_rsp.status       = r_ost;
    assign o_rsp.stack_depth  = r_odepth;

    `ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= CW'(DEPTH), "stack count beyond depth")
    `ASSERT_IMPLIES(a_count_at_fin, i_clk, i_rst_n, r_count != $past(r_count), $past(r_state) == S_FIN, "count changed outside result load")
    `ASSERT_IMPLIES(a_valid_from_fin, i_clk, i_rst_n, $rose(r_ovalid), $past(r_state) == S_FIN, "result valid without a finished item")
    `ASSERT_IMPLIES(a_div_done_state, i_clk, i_rst_n, w_div_done, r_state == S_DIV, "divider finished while not waiting")

endmodule

FILE: dv/stack_calculator_engine_tb.sv
module stack_calculator_engine_tb;

    localparam int DEPTH = scalc_pkg::DEPTH;
    localparam int DW    = scalc_pkg::DW;
    localparam int PW    = scalc_pkg::PW;
    localparam int SDW   = scalc_pkg::SDW;

    typedef struct packed {
        logic [DW-1:0]      value;
        scalc_pkg::t_status status;
        logic [SDW-1:0]     depth;
    } t_calc_result;

    typedef struct packed {
        scalc_pkg::t_opcode op;
        logic [DW-1:0]      operand;
        logic [PW-1:0]      index;
        bit                 typed;
        t_calc_result       reply;
    } t_dir_row;

    localparam t_calc_result UNTYPED = '{'0, scalc_pkg::ST_OK, '0};

    // Rows marked typed carry their result; the others are checked against the predictor.
    localparam t_dir_row DIRECTED [25] = '{
        '{scalc_pkg::OP_POP, 32'h0, 10'd0, 1'b1, '{32'h0, scalc_pkg::ST_EMPTY, 11'd0}},
        '{scalc_pkg::OP_PEEK_TOP, 32'h0, 10'd0, 1'b1, '{32'h0, scalc_pkg::ST_RANGE, 11'd0}},
        '{scalc_pkg::OP_PEEK_BOT, 32'hFFFF_FFFF, 10'd1023, 1'b1,
          '{32'h0, scalc_pkg::ST_RANGE, 11'd0}},
        '{scalc_pkg::OP_ADD, 32'h0, 10'd0, 1'b1, '{32'h0, scalc_pkg::ST_FEW, 11'd0}},
        '{scalc_pkg::OP_PUSH, 32'h7FFF_FFFF, 10'd0, 1'b1, '{32'h0, scalc_pkg::ST_OK, 11'd1}},
        '{scalc_pkg::OP_SUB, 32'h0, 10'd0, 1'b1, '{32'h0, scalc_pkg::ST_FEW, 11'd1}},
        '{scalc_pkg::OP_PUSH, 32'h0000_0001, 10'd0, 1'b0, UNTYPED},
        '{scalc_pkg::OP_ADD, 32'h0, 10'd0, 1'b1, '{32'h8000_0000, scalc_pkg::ST_OK, 11'd1}},
        '{scalc_pkg::OP_PUSH, 32'hFFFF_FFFF, 10'd1023, 1'b0, UNTYPED},
        '{scalc_pkg::OP_DIV, 32'h0, 10'd0, 1'b1, '{32'h8000_0000, scalc_pkg::ST_OK, 11'd1}},
        '{scalc_pkg::OP_PUSH, 32'h0, 10'd0, 1'b0, UNTYPED},
        '{scalc_pkg::OP_DIV, 32'h0, 10'd0, 1'b1, '{32'h0, scalc_pkg::ST_DIVZ, 11'd0}},
        '{scalc_pkg::OP_PUSH, 32'hFFFF_FFF9, 10'd0, 1'b0, UNTYPED},
        '{scalc_pkg::OP_PUSH, 32'h0000_0002, 10'd0, 1'b0, UNTYPED},
        '{scalc_pkg::OP_DIV, 32'h0, 10'd0, 1'b0, UNTYPED},
        '{scalc_pkg::OP_PUSH, 32'h0000_0007, 10'd0, 1'b0, UNTYPED},
        '{scalc_pkg::OP_PUSH, 32'hFFFF_FFFE, 10'd0, 1'b0, UNTYPED},
        '{scalc_pkg::OP_DIV, 32'h0, 10'd0, 1'b0, UNTYPED},
        '{scalc_pkg::OP_MUL, 32'h0, 10'd0, 1'b0, UNTYPED},
        '{scalc_pkg::OP_PUSH, 32'h8000_0000, 10'd0, 1'b0, UNTYPED},
        '{scalc_pkg::OP_PEEK_TOP, 32'h0, 10'd0, 1'b0, UNTYPED},
        '{scalc_pkg::OP_PEEK_BOT, 32'h0, 10'd0, 1'b0, UNTYPED},
        '{scalc_pkg::OP_PEEK_TOP, 32'h0, 10'd2, 1'b1, '{32'h0, scalc_pkg::ST_RANGE, 11'd2}},
        '{scalc_pkg::OP_SUB, 32'h0, 10'd0, 1'b0, UNTYPED},
        '{scalc_pkg::OP_POP, 32'h0, 10'd0, 1'b0, UNTYPED}
    };

    logic i_clk;
    logic i_rst_n;

    scalc_cmd_if cmd_if ();
    scalc_rsp_if rsp_if ();

    stack_calculator_engine dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_rsp   (rsp_if)
    );

    logic [DW-1:0] shadow_stack [DEPTH];
    int unsigned   shadow_depth;
    int unsigned   peak_depth;
    t_calc_result  awaited_replies [$];
    int            errors;
    int            commands;
    int            replies;
    int            status_seen [8];
    bit            no_idle;
    bit            stall_request;

    initial begin
        i_clk = 1'b0;
    end

    always #5 i_clk = ~i_clk;

    initial begin
        #10_000_000;
        $display("stack_calculator_engine: mismatch");
        $finish;
    end

    function automatic t_calc_result rpn_execute(scalc_pkg::t_opcode op,
                                                 logic [DW-1:0] operand,
                                                 logic [PW-1:0] index);
        t_calc_result  r;
        logic [DW-1:0] top;
        logic [DW-1:0] second;
        longint        num;
        longint        den;
        longint        quo;
        r = UNTYPED;
        case (op)
            scalc_pkg::OP_PUSH: begin
                if (shadow_depth >= DEPTH) begin
                    r.status = scalc_pkg::ST_FULL;
                end else begin
                    shadow_stack[shadow_depth] = operand;
                    shadow_depth++;
                end
            end
            scalc_pkg::OP_POP: begin
                if (shadow_depth == 0) begin
                    r.status = scalc_pkg::ST_EMPTY;
                end else begin
                    shadow_depth--;
                    r.value = shadow_stack[shadow_depth];
                end
            end
            scalc_pkg::OP_PEEK_TOP, scalc_pkg::OP_PEEK_BOT: begin
                if (index >= shadow_depth) begin
                    r.status = scalc_pkg::ST_RANGE;
                end else if (op == scalc_pkg::OP_PEEK_TOP) begin
                    r.value = shadow_stack[shadow_depth - index - 1];
                end else begin
                    r.value = shadow_stack[index];
                end
            end
            default: begin
                if (shadow_depth < 2) begin
                    r.status = scalc_pkg::ST_FEW;
                end else begin
                    top    = shadow_stack[shadow_depth - 1];
                    second = shadow_stack[shadow_depth - 2];
                    shadow_depth -= 2;
                    case (op)
                        scalc_pkg::OP_ADD: r.value = second + top;
                        scalc_pkg::OP_SUB: r.value = second - top;
                        scalc_pkg::OP_MUL: r.value = second * top;
                        default: begin
                            if (top == '0) begin
                                r.status = scalc_pkg::ST_DIVZ;
                            end else begin
                                num = longint'($signed(second));
                                den = longint'($signed(top));
                                quo = num / den;
                                if ((num % den) != 0 && ((num < 0) != (den < 0))) begin
                                    quo = quo - 1;
                                end
                                r.value = quo[DW-1:0];
                            end
                        end
                    endcase
                    if (r.status == scalc_pkg::ST_OK) begin
                        shadow_stack[shadow_depth] = r.value;
                        shadow_depth++;
                    end
                end
            end
        endcase
        r.depth = shadow_depth[SDW-1:0];
        return r;
    endfunction

    function automatic logic [DW-1:0] pick_operand();
        case ($urandom_range(7))
            0:       return '0;
            1:       return 32'h0000_0001;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h8000_0000;
            4:       return 32'h7FFF_FFFF;
            5, 6:    return $urandom_range(200) - 100;
            default: return $urandom;
        endcase
    endfunction

    task automatic flag_reply(input string msg);
        $display("ERROR: result %0d: %s", replies, msg);
        errors++;
    endtask

    task automatic issue(input scalc_pkg::t_opcode op, input logic [DW-1:0] operand,
                         input logic [PW-1:0] index, input bit typed,
                         input t_calc_result typed_reply);
        t_calc_result predicted;
        int           gap;
        gap = 0;
        while (!no_idle && $urandom_range(99) < 18) gap++;
        if (gap > 0) begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_if.valid      <= 1'b1;
        cmd_if.opcode     <= op;
        cmd_if.push_value <= operand;
        cmd_if.peek_index <= index;
        @(posedge i_clk);
        while (!cmd_if.ready) @(posedge i_clk);
        predicted = rpn_execute(op, operand, index);
        awaited_replies.push_back(typed ? typed_reply : predicted);
        commands++;
        if (shadow_depth > peak_depth) peak_depth = shadow_depth;
    endtask

    // Mostly shallow expression evaluation, with some items of any kind mixed in.
    task automatic random_item();
        int                 roll;
        scalc_pkg::t_opcode op;
        logic [PW-1:0]      index;
        roll  = $urandom_range(99);
        index = '0;
        if (roll < 8) begin
            op    = scalc_pkg::t_opcode'($urandom_range(scalc_pkg::OP_PUSH, scalc_pkg::OP_DIV));
            index = PW'($urandom_range(1023));
        end else if (shadow_depth < 2 || (shadow_depth < 16 && roll < 50)) begin
            op = scalc_pkg::OP_PUSH;
        end else begin
            op = scalc_pkg::t_opcode'($urandom_range(scalc_pkg::OP_POP, scalc_pkg::OP_DIV));
            if (op == scalc_pkg::OP_PEEK_TOP || op == scalc_pkg::OP_PEEK_BOT) begin
                index = PW'($urandom_range(shadow_depth - 1));
            end
        end
        issue(op, pick_operand(), index, 1'b0, UNTYPED);
    endtask

    task automatic wait_for_replies();
        while (awaited_replies.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        cmd_if.valid      <= 1'b0;
        cmd_if.opcode     <= scalc_pkg::OP_PUSH;
        cmd_if.push_value <= '0;
        cmd_if.peek_index <= '0;
        i_rst_n           <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < $size(DIRECTED); i++) begin
            issue(DIRECTED[i].op, DIRECTED[i].operand, DIRECTED[i].index,
                  DIRECTED[i].typed, DIRECTED[i].reply);
        end

        repeat (300) random_item();
        cmd_if.valid <= 1'b0;
        wait_for_replies();

        for (int n = 0; n < 300; n++) begin
            if (n == 100) stall_request = 1'b1;
            if (n == 180) no_idle = 1'b1;
            random_item();
        end
        no_idle = 1'b0;
        cmd_if.valid <= 1'b0;

        wait_for_replies();
        repeat (64) @(posedge i_clk);
        $display("Sent %0d items (%0d from the directed table), checked %0d results; %s %0d.",
                 commands, $size(DIRECTED), replies, "deepest stack", peak_depth);
        $display("Error results: empty %0d, range %0d, few operands %0d, div by zero %0d.",
                 status_seen[scalc_pkg::ST_EMPTY], status_seen[scalc_pkg::ST_RANGE],
                 status_seen[scalc_pkg::ST_FEW], status_seen[scalc_pkg::ST_DIVZ]);
        if (errors == 0) begin
            $display("stack_calculator_engine: match");
        end else begin
            $display("stack_calculator_engine: mismatch");
        end
        $finish;
    end

    initial begin
        int hold_off;
        hold_off = 0;
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off > 0) begin
                rsp_if.ready <= 1'b0;
                hold_off--;
            end else if (stall_request) begin
                stall_request = 1'b0;
                hold_off = 400;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= no_idle || ($urandom_range(99) >= 18);
            end
        end
    end

    always @(posedge i_clk) begin
        t_calc_result want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            replies++;
            status_seen[rsp_if.status]++;
            if (awaited_replies.size() == 0) begin
                flag_reply($sformatf("unexpected item value=%h status=%0d depth=%0d",
                                     rsp_if.result_value, rsp_if.status, rsp_if.stack_depth));
            end else begin
                want = awaited_replies.pop_front();
                if (rsp_if.result_value !== want.value) begin
                    flag_reply($sformatf("value expected %h got %h",
                                         want.value, rsp_if.result_value));
                end
                if (rsp_if.status !== want.status) begin
                    flag_reply($sformatf("status expected %0d got %0d",
                                         want.status, rsp_if.status));
                end
                if (rsp_if.stack_depth !== want.depth) begin
                    flag_reply($sformatf("depth expected %0d got %0d",
                                         want.depth, rsp_if.stack_depth));
                end
            end
        end
    end

endmodule
